// ===== rtl/rchi_pkg.sv =====
// ----------------------------------------------------------------------------
// rchi_pkg: shared types and constants for the ray convex hull clipper
// Holds the field widths, the register index codes and the queue word type.
// ----------------------------------------------------------------------------
package rchi_pkg;

	localparam int CoordW  = 16;
	localparam int EdgeW   = 17;
	localparam int NormW   = 35;
	localparam int DotW    = 54;
	localparam int MagW    = 53;
	localparam int TW      = 32;
	localparam int QDepth  = 4;

	localparam logic signed [TW-1:0] TMaxPos = 32'sh7FFF_FFFF;
	localparam logic signed [TW-1:0] TMinNeg = 32'sh8000_0000;

	typedef enum logic [2:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_ORIGIN_Z  = 3'd2,
		REG_HEADING_X = 3'd3,
		REG_HEADING_Y = 3'd4,
		REG_HEADING_Z = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_UPD,
		BK_OUT
	} bk_state_t;

	// One classified plane, handed from the front to the back.
	typedef struct packed {
		logic signed [DotW-1:0] numer;
		logic signed [DotW-1:0] denom;
		logic                   last;
	} plane_t;

endpackage

// ===== rtl/rchi_front.sv =====
// ----------------------------------------------------------------------------
// rchi_front: plane setup
// Three-stage pipeline: edges, cross product, then the two dot products.
// ----------------------------------------------------------------------------
module rchi_front import rchi_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CoordW-1:0] v [9],
	input  logic                     in_last,
	input  logic signed [CoordW-1:0] pos [3],
	input  logic signed [CoordW-1:0] dir [3],
	output logic                     out_valid,
	input  logic                     out_ready,
	output plane_t                   out_plane
);

	logic                    v_s1, v_s2, v_s3;
	logic signed [EdgeW-1:0] e1_s1 [3];
	logic signed [EdgeW-1:0] e2_s1 [3];
	logic signed [EdgeW-1:0] d_s1 [3];
	logic                    l_s1, l_s2;
	logic signed [NormW-1:0] n_s2 [3];
	logic signed [EdgeW-1:0] d_s2 [3];
	plane_t                  p_s3;
	logic                    adv;

	assign adv      = !v_s3 || out_ready;
	assign in_ready = adv;
	assign out_valid = v_s3;
	assign out_plane = p_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				e1_s1[k] <= EdgeW'(v[3+k]) - EdgeW'(v[k]);
				e2_s1[k] <= EdgeW'(v[6+k]) - EdgeW'(v[3+k]);
				d_s1[k]  <= EdgeW'(v[k]) - EdgeW'(pos[k]);
			end
			l_s1 <= in_last;
			n_s2[0] <= NormW'(e1_s1[1] * e2_s1[2]) - NormW'(e1_s1[2] * e2_s1[1]);
			n_s2[1] <= NormW'(e1_s1[2] * e2_s1[0]) - NormW'(e1_s1[0] * e2_s1[2]);
			n_s2[2] <= NormW'(e1_s1[0] * e2_s1[1]) - NormW'(e1_s1[1] * e2_s1[0]);
			d_s2 <= d_s1;
			l_s2 <= l_s1;
			p_s3.denom <= DotW'(n_s2[0] * dir[0]) + DotW'(n_s2[1] * dir[1])
				+ DotW'(n_s2[2] * dir[2]);
			p_s3.numer <= DotW'(n_s2[0] * d_s2[0]) + DotW'(n_s2[1] * d_s2[1])
				+ DotW'(n_s2[2] * d_s2[2]);
			p_s3.last <= l_s2;
		end
	end

endmodule

// ===== rtl/rchi_queue.sv =====
// ----------------------------------------------------------------------------
// rchi_queue: plane queue
// Small FIFO that decouples plane setup from the bound update.
// ----------------------------------------------------------------------------
module rchi_queue import rchi_pkg::*; #(
	parameter int Depth = QDepth
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_valid,
	output logic   wr_ready,
	input  plane_t wr_data,
	output logic   rd_valid,
	input  logic   rd_ready,
	output plane_t rd_data
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	plane_t            mem_q [Depth];
	logic [AW-1:0]     wp_q, rp_q;
	logic [AW:0]       cnt_q;
	logic              wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

// ===== rtl/rchi_div.sv =====
// ----------------------------------------------------------------------------
// rchi_div: restoring divider
// Computes num * 2^16 / den one quotient bit a cycle from the magnitudes, then applies the sign, with saturation.
// ----------------------------------------------------------------------------
module rchi_div import rchi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [DotW-1:0] num,
	input  logic signed [DotW-1:0] den,
	output logic                   done,
	output logic signed [TW-1:0]   t
);

	localparam int QW = 32;

	logic [MagW-1:0] d_q;
	logic [MagW:0]   r_q;
	logic [MagW-1:0] n_q;
	logic [QW-1:0]   q_q;
	logic [6:0]      cnt_q;
	logic            busy_q, neg_q;
	logic [MagW:0]   r_sh;
	logic [MagW:0]   r_sub;

	// Numerator shifts in MSB first, then 16 zero bits for the fraction.
	assign r_sh  = {r_q[MagW-1:0], n_q[MagW-1]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(MagW + 16);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	logic [QW-1:0]  mag;
	logic           sat_q;

	// A set bit shifted out of the top of the quotient register means the
	// result no longer fits, so the saturation flag latches.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DotW-1] ^ den[DotW-1];
			n_q   <= num[DotW-1] ? MagW'(-num) : MagW'(num);
			d_q   <= den[DotW-1] ? MagW'(-den) : MagW'(den);
			r_q   <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			n_q <= {n_q[MagW-2:0], 1'b0};
			if (q_q[QW-1]) sat_q <= 1'b1;
			if (!r_sub[MagW]) begin
				r_q <= r_sub;
				q_q <= {q_q[QW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[QW-2:0], 1'b0};
			end
		end
	end

	assign mag = q_q;
	always_comb begin
		if (sat_q || mag[QW-1])
			t = neg_q ? TMinNeg : TMaxPos;
		else
			t = neg_q ? -$signed(mag) : $signed(mag);
	end

endmodule

// ===== rtl/rchi_back.sv =====
// ----------------------------------------------------------------------------
// rchi_back: bound update
// Pops a plane, divides unless the plane is parallel or the ray already missed,
// updates the interval and emits on the last plane.
module rchi_back import rchi_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  plane_t        in_plane,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          out_hit,
	output logic [TW-2:0] out_dist
);

	bk_state_t             st_q, st_d;
	logic signed [TW-1:0]  lo_q, hi_q;
	logic                  miss_q, last_q, dneg_q;
	logic                  start, done;
	logic signed [TW-1:0]  t;
	logic                  zero_den;

	rchi_div u_div (
		.clk, .arst_n, .start,
		.num(in_plane.numer), .den(in_plane.denom),
		.done, .t
	);

	assign zero_den = in_plane.denom == '0;
	assign out_valid = st_q == BK_OUT;

	always_comb begin
		st_d = st_q;
		in_ready = 1'b0;
		start = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!miss_q && !zero_den) begin
						start = 1'b1;
						st_d = BK_DIV;
					end else if (in_plane.last) begin
						st_d = BK_OUT;
					end
				end
			end
			BK_DIV: if (done) st_d = BK_UPD;
			BK_UPD: st_d = last_q ? BK_OUT : BK_IDLE;
			BK_OUT: if (out_ready) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BK_IDLE;
			lo_q   <= '0;
			hi_q   <= TMaxPos;
			miss_q <= 1'b0;
			last_q <= 1'b0;
			dneg_q <= 1'b0;
			out_hit  <= 1'b0;
			out_dist <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == BK_IDLE && in_valid) begin
				last_q <= in_plane.last;
				dneg_q <= in_plane.denom[DotW-1];
				if (!miss_q && zero_den) begin
					if (in_plane.last) begin
						out_hit <= 1'b0;
						out_dist <= '0;
						lo_q <= '0; hi_q <= TMaxPos; miss_q <= 1'b0;
					end else miss_q <= 1'b1;
				end else if (miss_q && in_plane.last) begin
					out_hit <= 1'b0;
					out_dist <= '0;
					lo_q <= '0; hi_q <= TMaxPos; miss_q <= 1'b0;
				end
			end
			if (st_q == BK_UPD) begin
				logic signed [TW-1:0] lo_n, hi_n;
				lo_n = (dneg_q && t > lo_q) ? t : lo_q;
				hi_n = (!dneg_q && t < hi_q) ? t : hi_q;
				if (last_q) begin
					out_hit  <= !(lo_n > hi_n);
					out_dist <= (lo_n > hi_n) ? '0 : lo_n[TW-2:0];
					lo_q <= '0; hi_q <= TMaxPos; miss_q <= 1'b0;
				end else begin
					lo_q <= lo_n;
					hi_q <= hi_n;
					miss_q <= lo_n > hi_n;
				end
			end
		end
	end

endmodule

// ===== rtl/ray_convex_hull_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_convex_hull_intersect: Cyrus-Beck ray clip against a streamed hull
// Clips the configured ray against the planes of a convex hull.
// ----------------------------------------------------------------------------
// Each input word is one hull triangle; the word flagged tlast closes the hull
// and produces one output word (hit, entry distance in unsigned Q15.16; zero
// on a miss). Plane setup runs as a three-stage pipeline feeding a four-entry
// queue, so triangles are taken back to back until the queue fills. The bound
// update pops one triangle at a time and takes no new one until it is done:
// a bit-serial division (69 quotient bits), then the interval update; a
// triangle met after a miss or with a parallel plane skips the division.
// The bound update thus sets the sustained rate. Ray registers are written on
// cfg_we with cfg_addr 0..5 (origin x,y,z then heading x,y,z, signed Q8.8);
// the user must write them only while the block is idle (not enforced here).
module ray_convex_hull_intersect import rchi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_addr,
	input  logic [CoordW-1:0]   cfg_wdata,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// vert_a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
	input  logic [9*CoordW-1:0] s_axis_tdata,
	input  logic                s_axis_tlast,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// entry_distance in bits 30:0, zero fill at bit 31
	output logic [31:0]         m_axis_tdata,
	// hit
	output logic                m_axis_tuser
);

	logic signed [CoordW-1:0] pos_q [3];
	logic signed [CoordW-1:0] dir_q [3];
	logic signed [CoordW-1:0] v [9];
	logic                     f_valid, f_ready, b_valid, b_ready;
	plane_t                   f_plane, b_plane;
	logic [TW-2:0]            entry_dist;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '{default: '0};
			dir_q <= '{default: '0};
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ORIGIN_X:  pos_q[0] <= cfg_wdata;
				REG_ORIGIN_Y:  pos_q[1] <= cfg_wdata;
				REG_ORIGIN_Z:  pos_q[2] <= cfg_wdata;
				REG_HEADING_X: dir_q[0] <= cfg_wdata;
				REG_HEADING_Y: dir_q[1] <= cfg_wdata;
				REG_HEADING_Z: dir_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++) v[k] = s_axis_tdata[k*CoordW +: CoordW];
	end

	rchi_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.v, .in_last(s_axis_tlast), .pos(pos_q), .dir(dir_q),
		.out_valid(f_valid), .out_ready(f_ready), .out_plane(f_plane)
	);

	rchi_queue #(.Depth(QDepth)) u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_plane),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_plane)
	);

	rchi_back u_back (
		.clk, .arst_n,
		.in_valid(b_valid), .in_ready(b_ready), .in_plane(b_plane),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_hit(m_axis_tuser), .out_dist(entry_dist)
	);

	assign m_axis_tdata = {1'b0, entry_dist};

endmodule
